// ===== hdl/positional_array_list_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the positional array list core
// Shared same-cycle-implication and next-cycle-implication checks.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_ARRAY_LIST_CORE_ASSERT_SVH
`define POSITIONAL_ARRAY_LIST_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PALC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("palc assertion failed");

// antecedent implies consequent in the next cycle
`define PALC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("palc assertion failed");

`endif

// ===== hdl/palc_pkg.sv =====
// ----------------------------------------------------------------------------
// palc_pkg
// Operation and status codes, port widths and controller/datapath bundles.
// ----------------------------------------------------------------------------
package palc_pkg;

   localparam int OP_W      = 3;
   localparam int POS_W     = 7;
   localparam int DATA_W    = 32;
   localparam int STAT_W    = 2;
   localparam int CNT_OUT_W = 8;

   localparam int DEF_CAPACITY    = 128;
   localparam int DEF_VALUE_WIDTH = 32;

   localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_END   = 3'd1;
   localparam logic [OP_W-1:0] OP_INS_POS   = 3'd2;
   localparam logic [OP_W-1:0] OP_REM_FRONT = 3'd3;
   localparam logic [OP_W-1:0] OP_REM_END   = 3'd4;
   localparam logic [OP_W-1:0] OP_REM_POS   = 3'd5;

   localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd1;
   localparam logic [STAT_W-1:0] ST_BADPOS = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

   // controller to datapath
   typedef struct packed {
      logic capture;   // latch request and classify it
      logic setup;     // load shift pointer and move count
      logic step;      // read one entry and queue its move
      logic finish;    // commit count, write inserted value, load result
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic do_ins;
      logic do_rem;
      logic moves_done;
      logic out_busy;
   } sts_type;

endpackage

// ===== hdl/positional_array_list_core.sv =====
// ----------------------------------------------------------------------------
// positional_array_list_core
// Fixed-capacity ordered list with insert and remove at front, end or index.
// ----------------------------------------------------------------------------
// Request channel (req_*): operation, position and value, one beat per
// request. Result channel (rsp_*): removed value, status and entry count,
// exactly one beat per request, in request order.
// A request runs from acceptance to its result beat through the accept cycle,
// classification, a read of each entry from the position to the end of the
// list through the entry memory (a queued move is written while the next
// entry is read), a check that the reads have run out, a drain of the last
// move and the commit. Position is the effective one (zero for the front,
// count or count - 1 for the end); rejected or undefined requests skip the reads.
// A new request is accepted as soon as the previous one has committed; its
// result sits in the output register while the next request is worked on.
// If the receiver stalls, the result is held and the next request waits
// in its commit cycle until the output register frees up.
// Reset empties the list (count zero) and drops any pending result; the
// entry memory is not cleared, entries at or above count are never read.
// ----------------------------------------------------------------------------
module positional_array_list_core
   import palc_pkg::*;
#(
   parameter int CAPACITY    = DEF_CAPACITY,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OP_W-1:0]      req_operation,
   input  logic [POS_W-1:0]     req_position,
   input  logic [DATA_W-1:0]    req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [DATA_W-1:0]    rsp_removed_value,
   output logic [STAT_W-1:0]    rsp_status,
   output logic [CNT_OUT_W-1:0] rsp_entry_count
);

   cmd_type cmd;
   sts_type sts;

   palc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   palc_dp #(
      .CAPACITY    (CAPACITY),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_operation     (req_operation),
      .req_position      (req_position),
      .req_value         (req_value),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_removed_value (rsp_removed_value),
      .rsp_status        (rsp_status),
      .rsp_entry_count   (rsp_entry_count)
   );

endmodule

// ===== hdl/palc_dp.sv =====
// ----------------------------------------------------------------------------
// palc_dp
// Entry memory, count, shift pointers and result register of the list core.
// ----------------------------------------------------------------------------
module palc_dp
   import palc_pkg::*;
#(
   parameter int CAPACITY    = DEF_CAPACITY,
   parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output sts_type              sts,
   input  logic [OP_W-1:0]      req_operation,
   input  logic [POS_W-1:0]     req_position,
   input  logic [DATA_W-1:0]    req_value,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [DATA_W-1:0]    rsp_removed_value,
   output logic [STAT_W-1:0]    rsp_status,
   output logic [CNT_OUT_W-1:0] rsp_entry_count
);

   localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int IDX_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [VALUE_WIDTH-1:0] mem [CAPACITY];

   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   ins_ff, rem_ff;
   logic [STAT_W-1:0]      status_ff, status_in;
   logic [CNT_W-1:0]       at_ff;
   logic [VALUE_WIDTH-1:0] val_ff;
   logic [CNT_W-1:0]       rptr_ff;
   logic [CNT_W-1:0]       moves_ff;
   logic                   first_ff;
   logic                   wpend_ff;
   logic [ADDR_W-1:0]      waddr_ff, waddr_in;
   logic                   grab_ff;
   logic [VALUE_WIDTH-1:0] rdata_ff;
   logic [VALUE_WIDTH-1:0] removed_ff;
   logic                   rsp_valid_ff;
   logic [DATA_W-1:0]      rsp_removed_ff;
   logic [STAT_W-1:0]      rsp_status_ff;
   logic [CNT_OUT_W-1:0]   rsp_count_ff;

   logic                   is_ins, is_rem, act_ins, act_rem;
   logic [IDX_W-1:0]       cnt_ext, pos_ext, at_ext;
   logic                   wr_en;
   logic [ADDR_W-1:0]      wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;
   logic [63:0]            val_wide, removed_wide;
   logic [15:0]            cnt_wide;

   // classify the incoming request against the current count
   always_comb begin
      cnt_ext   = IDX_W'(count_ff);
      pos_ext   = IDX_W'(req_position);
      is_ins    = 1'b0;
      is_rem    = 1'b0;
      at_ext    = '0;
      status_in = ST_OK;
      act_ins   = 1'b0;
      act_rem   = 1'b0;
      unique case (req_operation)
         OP_INS_FRONT: begin is_ins = 1'b1; at_ext = '0;      end
         OP_INS_END:   begin is_ins = 1'b1; at_ext = cnt_ext; end
         OP_INS_POS:   begin is_ins = 1'b1; at_ext = pos_ext; end
         OP_REM_FRONT: begin is_rem = 1'b1; at_ext = '0;      end
         OP_REM_END:   begin is_rem = 1'b1; at_ext = cnt_ext - IDX_W'(1); end
         OP_REM_POS:   begin is_rem = 1'b1; at_ext = pos_ext; end
         default:      ;
      endcase
      if (is_ins) begin
         if (at_ext > cnt_ext) begin
            status_in = ST_BADPOS;
         end else if (count_ff == CNT_W'(CAPACITY)) begin
            status_in = ST_FULL;
         end else begin
            act_ins = 1'b1;
         end
      end
      if (is_rem) begin
         if (count_ff == '0) begin
            status_in = ST_EMPTY;
         end else if (at_ext >= cnt_ext) begin
            status_in = ST_BADPOS;
         end else begin
            act_rem = 1'b1;
         end
      end
   end

   assign val_wide = 64'(req_value);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         status_ff <= status_in;
         at_ff     <= at_ext[CNT_W-1:0];
         val_ff    <= val_wide[VALUE_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ins_ff <= 1'b0;
         rem_ff <= 1'b0;
      end else if (cmd.capture) begin
         ins_ff <= act_ins;
         rem_ff <= act_rem;
      end
   end

   // shift sequencing: insert walks down from count-1, remove walks up from at
   assign waddr_in = ins_ff ? ADDR_W'(rptr_ff + CNT_W'(1)) : ADDR_W'(rptr_ff - CNT_W'(1));

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         rptr_ff  <= ins_ff ? (count_ff - CNT_W'(1)) : at_ff;
         moves_ff <= count_ff - at_ff;
      end else if (cmd.step) begin
         rptr_ff  <= ins_ff ? (rptr_ff - CNT_W'(1)) : (rptr_ff + CNT_W'(1));
         moves_ff <= moves_ff - CNT_W'(1);
      end
      if (cmd.step) begin
         waddr_ff <= waddr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b0;
         wpend_ff <= 1'b0;
         grab_ff  <= 1'b0;
      end else begin
         if (cmd.setup) begin
            first_ff <= 1'b1;
         end else if (cmd.step) begin
            first_ff <= 1'b0;
         end
         // first read of a removal fetches the removed value, no move
         wpend_ff <= cmd.step & ~(rem_ff & first_ff);
         grab_ff  <= cmd.step & rem_ff & first_ff;
      end
   end

   assign wr_en   = wpend_ff | (cmd.finish & ins_ff);
   assign wr_addr = wpend_ff ? waddr_ff : at_ff[ADDR_W-1:0];
   assign wr_data = wpend_ff ? rdata_ff : val_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.step) begin
         rdata_ff <= mem[rptr_ff[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (grab_ff) begin
         removed_ff <= rdata_ff;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (ins_ff) begin
         count_in = count_ff + CNT_W'(1);
      end else if (rem_ff) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.finish) begin
         count_ff <= count_in;
      end
   end

   assign removed_wide = 64'(removed_ff);
   assign cnt_wide     = 16'(count_in);

   // result register: hold until the receiver takes the beat
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_removed_ff <= rem_ff ? removed_wide[DATA_W-1:0] : '0;
         rsp_status_ff  <= status_ff;
         rsp_count_ff   <= cnt_wide[CNT_OUT_W-1:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_count   = rsp_count_ff;

   assign sts.do_ins     = ins_ff;
   assign sts.do_rem     = rem_ff;
   assign sts.moves_done = (moves_ff == '0);
   assign sts.out_busy   = rsp_valid_ff & ~rsp_ready;

`include "positional_array_list_core_assert.svh"

   `PALC_ASSERT_NOW(a_no_rw_clash, clock, reset, wr_en && cmd.step,
                    wr_addr != rptr_ff[ADDR_W-1:0])
   `PALC_ASSERT_NOW(a_no_result_overrun, clock, reset, cmd.finish,
                    !(rsp_valid_ff && !rsp_ready))
   `PALC_ASSERT_NEXT(a_insert_grows, clock, reset, cmd.finish && ins_ff,
                     count_ff == $past(count_ff) + CNT_W'(1))
   `PALC_ASSERT_NOW(a_grab_only_remove, clock, reset, grab_ff, rem_ff && !ins_ff)

endmodule

// ===== hdl/palc_ctrl.sv =====
// ----------------------------------------------------------------------------
// palc_ctrl
// Request sequencer: classify, shift entries one per cycle, commit, respond.
// ----------------------------------------------------------------------------
module palc_ctrl
   import palc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_CHECK  = 3'd1;
   localparam logic [2:0] S_SHIFT  = 3'd2;
   localparam logic [2:0] S_DRAIN  = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0] state_ff, state_in;

   always_comb begin
      state_in    = state_ff;
      req_ready   = 1'b0;
      cmd         = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.do_ins || sts.do_rem) begin
               cmd.setup = 1'b1;
               state_in  = S_SHIFT;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SHIFT: begin
            if (sts.moves_done) begin
               state_in = S_DRAIN;
            end else begin
               cmd.step = 1'b1;
            end
         end
         // let the last queued move land
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!sts.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
